// File: rtl/pmt_discriminator_window_trigger_unit_macros.svh
// Assertion helpers for the trigger unit.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef PMT_DISCRIMINATOR_WINDOW_TRIGGER_UNIT_MACROS_SVH
`define PMT_DISCRIMINATOR_WINDOW_TRIGGER_UNIT_MACROS_SVH

// Check a condition on every clock outside reset
`define PDWT_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition in one cycle implies another in the next
`define PDWT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/pdwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdwt_pkg
// Shared widths, codes, reset values and types of the trigger unit.
// ----------------------------------------------------------------------------
package pdwt_pkg;

  // default parameter values
  localparam int DEF_NUM_CHANNELS      = 32;
  localparam int DEF_MAX_TICKS         = 4096;
  localparam int DEF_FIRST_DELAY       = 4;
  localparam int DEF_SECOND_DELAY      = 4;
  localparam int DEF_MIN_READOUT_TICKS = 20;
  localparam int DEF_SAMPLE_BITS       = 12;

  // field widths
  localparam int REQ_W      = 2;
  localparam int ADC_W      = 12;
  localparam int WIN_W      = 12;
  localparam int SUM_W      = 17;
  localparam int HIT_W      = 6;
  localparam int CNT_W      = 12;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;
  localparam int THR_W      = 12;
  localparam int SPAN_W     = 8;
  localparam int FRONT_W    = 12;

  typedef logic [REQ_W-1:0]     req_t;
  typedef logic [STAT_W-1:0]    status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // request codes
  localparam req_t REQ_START = 2'd0;
  localparam req_t REQ_PUSH  = 2'd1;
  localparam req_t REQ_READ  = 2'd2;

  // result status codes
  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_SHORT      = 2'd1;
  localparam status_t ST_RANGE      = 2'd2;
  localparam status_t ST_INCOMPLETE = 2'd3;

  // register indexes
  localparam cfg_idx_t CFG_FIRST_THRESHOLD  = 4'd0;
  localparam cfg_idx_t CFG_FIRST_PRECOUNT   = 4'd1;
  localparam cfg_idx_t CFG_FIRST_PREWINDOW  = 4'd2;
  localparam cfg_idx_t CFG_SECOND_THRESHOLD = 4'd3;
  localparam cfg_idx_t CFG_SECOND_DEADTIME  = 4'd4;
  localparam cfg_idx_t CFG_SECOND_WIDTH     = 4'd5;
  localparam cfg_idx_t CFG_FRONT_BUFFER     = 4'd6;
  localparam cfg_idx_t CFG_WINDOW_SIZE      = 4'd7;

  // register reset values
  localparam logic [THR_W-1:0]   RST_FIRST_THRESHOLD  = 12'd5;
  localparam logic [SPAN_W-1:0]  RST_FIRST_PRECOUNT   = 8'd3;
  localparam logic [SPAN_W-1:0]  RST_FIRST_PREWINDOW  = 8'd6;
  localparam logic [THR_W-1:0]   RST_SECOND_THRESHOLD = 12'd10;
  localparam logic [SPAN_W-1:0]  RST_SECOND_DEADTIME  = 8'd6;
  localparam logic [SPAN_W-1:0]  RST_SECOND_WIDTH     = 8'd6;
  localparam logic [FRONT_W-1:0] RST_FRONT_BUFFER     = 12'd20;
  localparam logic [SPAN_W-1:0]  RST_WINDOW_SIZE      = 8'd6;

  // saturation limits of the per-tick sums
  localparam logic [SUM_W-1:0] SUM_MAX = 17'h1FFFF;
  localparam logic [HIT_W-1:0] HIT_MAX = 6'h3F;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [CNT_W-1:0]  num;
    logic [SPAN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quot;
  } div_rsp_t;

endpackage

// File: rtl/pdwt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdwt_in_if
// Request channel: start, push sample or read window.
// ----------------------------------------------------------------------------
interface pdwt_in_if;
  logic                        valid;
  logic                        ready;
  logic [pdwt_pkg::REQ_W-1:0]  req_type;
  logic [pdwt_pkg::ADC_W-1:0]  adc_sample;
  logic                        channel_end;
  logic [pdwt_pkg::WIN_W-1:0]  window_index;

  modport source (output valid, req_type, adc_sample, channel_end, window_index,
                  input ready);
  modport sink   (input valid, req_type, adc_sample, channel_end, window_index,
                  output ready);
endinterface

// File: rtl/pdwt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdwt_out_if
// Result channel: one window summary per read request.
// ----------------------------------------------------------------------------
interface pdwt_out_if;
  logic                         valid;
  logic                         ready;
  logic [pdwt_pkg::SUM_W-1:0]   window_peak_sum;
  logic [pdwt_pkg::HIT_W-1:0]   window_multiplicity;
  logic [pdwt_pkg::CNT_W-1:0]   window_count;
  logic [pdwt_pkg::STAT_W-1:0]  status;

  modport source (output valid, window_peak_sum, window_multiplicity, window_count,
                  status, input ready);
  modport sink   (input valid, window_peak_sum, window_multiplicity, window_count,
                  status, output ready);
endinterface

// File: rtl/pdwt_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdwt_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface pdwt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pdwt_pkg::CFG_IDX_W-1:0]  index;
  logic [pdwt_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/pdwt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdwt_div
// Restoring divider, one quotient bit per cycle, for the window count.
// ----------------------------------------------------------------------------
module pdwt_div (
  input  logic               clk,
  input  logic               rst_n,
  input  pdwt_pkg::div_req_t req,
  output pdwt_pkg::div_rsp_t rsp
);
  import pdwt_pkg::*;

  localparam int STEP_W = $clog2(CNT_W + 1);

  logic [SPAN_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]  quot_r, quot_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [SPAN_W-1:0] den_r, den_nxt;
  logic [SPAN_W:0]   trial;

  // shift in one numerator bit and try a subtract
  always_comb begin
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    den_nxt  = den_r;
    trial    = {rem_r, quot_r[CNT_W-1]};
    if (req.start) begin
      rem_nxt  = '0;
      quot_nxt = req.num;
      den_nxt  = req.den;
      step_nxt = STEP_W'(CNT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt  = SPAN_W'(trial - {1'b0, den_r});
        quot_nxt = {quot_r[CNT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[SPAN_W-1:0];
        quot_nxt = {quot_r[CNT_W-2:0], 1'b0};
      end
      step_nxt = step_r - 1'b1;
      if (step_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    den_r  <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

// File: rtl/pmt_discriminator_window_trigger_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmt_discriminator_window_trigger_unit
// Two-stage difference discriminator over loaded channels, per-tick peak and
// hit sums, and a per-window maximum query.
// ----------------------------------------------------------------------------
// Push: the last push of a channel starts a scan of every tick, with a width
//   search and a deadtime accumulate on each fire (sample memory with one
//   read port, read three times per tick).
// Read: window count by divider, then window maximum to the result register.
// Start: clears the sum memories, not ready meanwhile.
// Reset: registers to defaults, then the same clearing pass.
module pmt_discriminator_window_trigger_unit #(
  parameter int NUM_CHANNELS      = pdwt_pkg::DEF_NUM_CHANNELS,
  parameter int MAX_TICKS         = pdwt_pkg::DEF_MAX_TICKS,
  parameter int FIRST_DELAY       = pdwt_pkg::DEF_FIRST_DELAY,
  parameter int SECOND_DELAY      = pdwt_pkg::DEF_SECOND_DELAY,
  parameter int MIN_READOUT_TICKS = pdwt_pkg::DEF_MIN_READOUT_TICKS,
  parameter int SAMPLE_BITS       = pdwt_pkg::DEF_SAMPLE_BITS
) (
  input logic         clk,
  input logic         rst_n,
  pdwt_in_if.sink     in_item,
  pdwt_out_if.source  out_item,
  pdwt_cfg_if.sink    cfg_wr
);
  import pdwt_pkg::*;
  `include "pmt_discriminator_window_trigger_unit_macros.svh"

  localparam int AW = $clog2(MAX_TICKS);
  localparam int PW = $clog2(MAX_TICKS + 1);
  localparam int CW = $clog2(NUM_CHANNELS + 1);
  localparam int EW = ((PW > SPAN_W) ? PW : SPAN_W) + 1;
  localparam int DW = ((SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W) + 2;
  localparam int MW = CNT_W + SPAN_W + 1;

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_T_RD0  = 5'd2;
  localparam logic [4:0] S_T_RD1  = 5'd3;
  localparam logic [4:0] S_T_RD2  = 5'd4;
  localparam logic [4:0] S_T_EVAL = 5'd5;
  localparam logic [4:0] S_P_CHK  = 5'd6;
  localparam logic [4:0] S_P_RD0  = 5'd7;
  localparam logic [4:0] S_P_RD1  = 5'd8;
  localparam logic [4:0] S_P_EVAL = 5'd9;
  localparam logic [4:0] S_A_CHK  = 5'd10;
  localparam logic [4:0] S_A_RD   = 5'd11;
  localparam logic [4:0] S_A_WR   = 5'd12;
  localparam logic [4:0] S_T_NEXT = 5'd13;
  localparam logic [4:0] S_Q_DIV  = 5'd14;
  localparam logic [4:0] S_Q_CMP  = 5'd15;
  localparam logic [4:0] S_Q_RD   = 5'd16;
  localparam logic [4:0] S_Q_MAX  = 5'd17;
  localparam logic [4:0] S_Q_OUT  = 5'd18;

  // configuration registers
  logic [THR_W-1:0]   first_threshold_r, second_threshold_r;
  logic [SPAN_W-1:0]  first_precount_r, first_prewindow_r;
  logic [SPAN_W-1:0]  second_deadtime_r, second_width_r, window_size_r;
  logic [FRONT_W-1:0] front_buffer_r;

  // memories
  logic [SAMPLE_BITS-1:0] buf_mem [MAX_TICKS];
  logic [SUM_W-1:0]       sum_mem [MAX_TICKS];
  logic [HIT_W-1:0]       hit_mem [MAX_TICKS];
  logic [SAMPLE_BITS-1:0] buf_rdata;
  logic [SUM_W-1:0]       sum_rdata;
  logic [HIT_W-1:0]       hit_rdata;

  // sequencer state
  logic [4:0]             state_r, state_nxt;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic [PW-1:0]          pos_r, pos_nxt;
  logic [PW-1:0]          len_r, len_nxt;
  logic [PW-1:0]          slen_r, slen_nxt;
  logic [CW-1:0]          chans_r, chans_nxt;
  logic [PW-1:0]          tick_r, tick_nxt;
  logic [PW-1:0]          u_r, u_nxt;
  logic [PW-1:0]          end_r, end_nxt;
  logic                   pre_seen_r, pre_seen_nxt;
  logic                   main_seen_r, main_seen_nxt;
  logic [PW-1:0]          pre_last_r, pre_last_nxt;
  logic [PW-1:0]          main_last_r, main_last_nxt;
  logic [SAMPLE_BITS-1:0] cur_r, cur_nxt;
  logic [SAMPLE_BITS-1:0] a_r, a_nxt;
  logic signed [DW-1:0]   peak_r, peak_nxt;
  logic [WIN_W-1:0]       idx_r, idx_nxt;
  logic [SPAN_W-1:0]      w_r, w_nxt;
  logic [SUM_W-1:0]       rsum_r, rsum_nxt;
  logic [HIT_W-1:0]       rhit_r, rhit_nxt;
  logic [CNT_W-1:0]       rcnt_r, rcnt_nxt;
  status_t                rstat_r, rstat_nxt;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0]       out_sum_r, out_sum_nxt;
  logic [HIT_W-1:0]       out_hit_r, out_hit_nxt;
  logic [CNT_W-1:0]       out_cnt_r, out_cnt_nxt;
  status_t                out_stat_r, out_stat_nxt;

  // memory controls
  logic                   buf_we;
  logic [AW-1:0]          buf_raddr;
  logic                   acc_we;
  logic [AW-1:0]          acc_waddr, acc_raddr;
  logic [SUM_W-1:0]       sum_wdata;
  logic [HIT_W-1:0]       hit_wdata;

  // evaluation terms
  logic                   in_acc;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic signed [DW-1:0]   d1, d2, thr1, thr2;
  logic                   main_free, pre_ok, pre_fire, pre_seen_e, main_fire;
  logic [PW-1:0]          pre_last_e;
  logic [EW-1:0]          span_w_end, span_d_end;
  logic [SUM_W:0]         sum_add;
  logic [MW-1:0]          q_start, q_end;
  logic [SPAN_W-1:0]      w_eff;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  function automatic logic signed [DW-1:0] sdiff(input logic [SAMPLE_BITS-1:0] x,
                                                 input logic [SAMPLE_BITS-1:0] y);
    return DW'(signed'({1'b0, x})) - DW'(signed'({1'b0, y}));
  endfunction

  pdwt_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_acc         = in_item.valid && in_item.ready;
  assign in_item.ready  = (state_r == S_IDLE);
  assign in_sample      = SAMPLE_BITS'(in_item.adc_sample);
  assign cfg_wr.ready   = 1'b1;

  assign out_item.valid               = out_valid_r;
  assign out_item.window_peak_sum     = out_sum_r;
  assign out_item.window_multiplicity = out_hit_r;
  assign out_item.window_count        = out_cnt_r;
  assign out_item.status              = out_stat_r;

  // discriminator terms for the current tick
  assign thr1 = DW'(signed'({1'b0, first_threshold_r}));
  assign thr2 = DW'(signed'({1'b0, second_threshold_r}));
  assign d1   = (tick_r >= PW'(FIRST_DELAY))  ? sdiff(cur_r, a_r)       : '0;
  assign d2   = (tick_r >= PW'(SECOND_DELAY)) ? sdiff(cur_r, buf_rdata) : '0;
  assign main_free = !main_seen_r ||
                     (EW'(main_last_r) + EW'(second_deadtime_r) < EW'(tick_r));
  assign pre_ok    = !pre_seen_r ||
                     (EW'(pre_last_r) + EW'(first_precount_r) < EW'(tick_r));
  assign pre_fire   = (d1 >= thr1) && pre_ok && main_free;
  assign pre_seen_e = pre_seen_r | pre_fire;
  assign pre_last_e = pre_fire ? tick_r : pre_last_r;
  assign main_fire  = (d2 >= thr2) && pre_seen_e && main_free &&
                      (EW'(tick_r - pre_last_e) < EW'(first_prewindow_r));
  assign span_w_end = EW'(tick_r) + EW'(second_width_r);
  assign span_d_end = EW'(tick_r) + EW'(second_deadtime_r);

  // saturating accumulate
  assign sum_add = (SUM_W + 1)'(sum_rdata) + (SUM_W + 1)'(peak_r[DW-2:0]);
  assign w_eff   = (window_size_r == '0) ? SPAN_W'(1) : window_size_r;
  assign q_start = MW'(front_buffer_r) + MW'(idx_r) * MW'(w_r);
  assign q_end   = q_start + MW'(w_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    pos_nxt       = pos_r;
    len_nxt       = len_r;
    slen_nxt      = slen_r;
    chans_nxt     = chans_r;
    tick_nxt      = tick_r;
    u_nxt         = u_r;
    end_nxt       = end_r;
    pre_seen_nxt  = pre_seen_r;
    main_seen_nxt = main_seen_r;
    pre_last_nxt  = pre_last_r;
    main_last_nxt = main_last_r;
    cur_nxt       = cur_r;
    a_nxt         = a_r;
    peak_nxt      = peak_r;
    idx_nxt       = idx_r;
    w_nxt         = w_r;
    rsum_nxt      = rsum_r;
    rhit_nxt      = rhit_r;
    rcnt_nxt      = rcnt_r;
    rstat_nxt     = rstat_r;
    out_valid_nxt = out_valid_r && !out_item.ready;
    out_sum_nxt   = out_sum_r;
    out_hit_nxt   = out_hit_r;
    out_cnt_nxt   = out_cnt_r;
    out_stat_nxt  = out_stat_r;
    buf_we        = 1'b0;
    buf_raddr     = tick_r[AW-1:0];
    acc_we        = 1'b0;
    acc_waddr     = u_r[AW-1:0];
    acc_raddr     = u_r[AW-1:0];
    sum_wdata     = '0;
    hit_wdata     = '0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = w_eff;

    unique case (state_r)
      S_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(MAX_TICKS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (in_item.req_type)
            REQ_START: begin
              pos_nxt   = '0;
              len_nxt   = '0;
              chans_nxt = '0;
              clr_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            REQ_PUSH: begin
              if (chans_r < CW'(NUM_CHANNELS)) begin
                buf_we = (pos_r < PW'(MAX_TICKS));
                if (buf_we) begin
                  pos_nxt = pos_r + 1'b1;
                end
                if (in_item.channel_end) begin
                  if (chans_r == '0) begin
                    len_nxt = pos_nxt;
                  end
                  slen_nxt      = pos_nxt;
                  pos_nxt       = '0;
                  chans_nxt     = chans_r + 1'b1;
                  tick_nxt      = '0;
                  pre_seen_nxt  = 1'b0;
                  main_seen_nxt = 1'b0;
                  pre_last_nxt  = '0;
                  main_last_nxt = '0;
                  state_nxt     = S_T_RD0;
                end
              end
            end
            REQ_READ: begin
              idx_nxt   = in_item.window_index;
              w_nxt     = w_eff;
              rsum_nxt  = '0;
              rhit_nxt  = '0;
              rcnt_nxt  = '0;
              rstat_nxt = ST_OK;
              state_nxt = S_Q_OUT;
              if (chans_r < CW'(NUM_CHANNELS)) begin
                rstat_nxt = ST_INCOMPLETE;
              end else if (len_r < PW'(MIN_READOUT_TICKS)) begin
                rstat_nxt = ST_SHORT;
              end else if (13'(len_r) - 13'd1 >= 13'(front_buffer_r)) begin
                div_req.start = 1'b1;
                div_req.num   = CNT_W'(13'(len_r) - 13'd1 - 13'(front_buffer_r));
                state_nxt     = S_Q_DIV;
              end else begin
                rstat_nxt = ST_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      // fetch sample, FIRST_DELAY and SECOND_DELAY taps of this tick
      S_T_RD0: begin
        buf_raddr = tick_r[AW-1:0];
        state_nxt = S_T_RD1;
      end
      S_T_RD1: begin
        buf_raddr = tick_r[AW-1:0] - AW'(FIRST_DELAY);
        cur_nxt   = buf_rdata;
        state_nxt = S_T_RD2;
      end
      S_T_RD2: begin
        buf_raddr = tick_r[AW-1:0] - AW'(SECOND_DELAY);
        a_nxt     = buf_rdata;
        state_nxt = S_T_EVAL;
      end
      S_T_EVAL: begin
        pre_seen_nxt = pre_seen_e;
        pre_last_nxt = pre_last_e;
        if (main_fire) begin
          main_seen_nxt = 1'b1;
          main_last_nxt = tick_r;
          peak_nxt      = d2;
          u_nxt         = tick_r;
          end_nxt       = (span_w_end > EW'(slen_r)) ? slen_r : span_w_end[PW-1:0];
          state_nxt     = S_P_CHK;
        end else begin
          state_nxt = S_T_NEXT;
        end
      end
      // search the peak difference over the width
      S_P_CHK: begin
        if (u_r >= end_r) begin
          u_nxt     = tick_r;
          end_nxt   = (span_d_end > EW'(slen_r)) ? slen_r : span_d_end[PW-1:0];
          state_nxt = S_A_CHK;
        end else begin
          state_nxt = S_P_RD0;
        end
      end
      S_P_RD0: begin
        buf_raddr = u_r[AW-1:0];
        state_nxt = S_P_RD1;
      end
      S_P_RD1: begin
        buf_raddr = u_r[AW-1:0] - AW'(SECOND_DELAY);
        cur_nxt   = buf_rdata;
        state_nxt = S_P_EVAL;
      end
      S_P_EVAL: begin
        if (u_r >= PW'(SECOND_DELAY)) begin
          if (sdiff(cur_r, buf_rdata) > peak_r) begin
            peak_nxt = sdiff(cur_r, buf_rdata);
          end
        end else if (peak_r < 0) begin
          peak_nxt = '0;
        end
        u_nxt     = u_r + 1'b1;
        state_nxt = S_P_CHK;
      end
      // add peak and hit over the deadtime span
      S_A_CHK: begin
        state_nxt = (u_r >= end_r) ? S_T_NEXT : S_A_RD;
      end
      S_A_RD: begin
        acc_raddr = u_r[AW-1:0];
        state_nxt = S_A_WR;
      end
      S_A_WR: begin
        acc_we    = 1'b1;
        acc_waddr = u_r[AW-1:0];
        sum_wdata = (sum_add > (SUM_W + 1)'(SUM_MAX)) ? SUM_MAX : sum_add[SUM_W-1:0];
        hit_wdata = (hit_rdata < HIT_MAX) ? hit_rdata + 1'b1 : hit_rdata;
        u_nxt     = u_r + 1'b1;
        state_nxt = S_A_CHK;
      end
      S_T_NEXT: begin
        tick_nxt  = tick_r + 1'b1;
        state_nxt = (tick_r + 1'b1 >= slen_r) ? S_IDLE : S_T_RD0;
      end
      // window query
      S_Q_DIV: begin
        if (div_rsp.done) begin
          rcnt_nxt  = div_rsp.quot;
          state_nxt = S_Q_CMP;
        end
      end
      S_Q_CMP: begin
        if (idx_r >= rcnt_r) begin
          rstat_nxt = ST_RANGE;
          state_nxt = S_Q_OUT;
        end else begin
          u_nxt     = q_start[PW-1:0];
          end_nxt   = q_end[PW-1:0];
          state_nxt = S_Q_RD;
        end
      end
      S_Q_RD: begin
        acc_raddr = u_r[AW-1:0];
        state_nxt = S_Q_MAX;
      end
      S_Q_MAX: begin
        if (sum_rdata > rsum_r) begin
          rsum_nxt = sum_rdata;
        end
        if (hit_rdata > rhit_r) begin
          rhit_nxt = hit_rdata;
        end
        u_nxt     = u_r + 1'b1;
        state_nxt = ((u_r + 1'b1 >= end_r) || (u_r + 1'b1 >= PW'(MAX_TICKS))) ?
                    S_Q_OUT : S_Q_RD;
      end
      // hand the result to the output register once it is free
      S_Q_OUT: begin
        if (!out_valid_r || out_item.ready) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = rsum_r;
          out_hit_nxt   = rhit_r;
          out_cnt_nxt   = rcnt_r;
          out_stat_nxt  = rstat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      pos_r       <= '0;
      len_r       <= '0;
      chans_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      pos_r       <= pos_nxt;
      len_r       <= len_nxt;
      chans_r     <= chans_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    slen_r      <= slen_nxt;
    tick_r      <= tick_nxt;
    u_r         <= u_nxt;
    end_r       <= end_nxt;
    pre_seen_r  <= pre_seen_nxt;
    main_seen_r <= main_seen_nxt;
    pre_last_r  <= pre_last_nxt;
    main_last_r <= main_last_nxt;
    cur_r       <= cur_nxt;
    a_r         <= a_nxt;
    peak_r      <= peak_nxt;
    idx_r       <= idx_nxt;
    w_r         <= w_nxt;
    rsum_r      <= rsum_nxt;
    rhit_r      <= rhit_nxt;
    rcnt_r      <= rcnt_nxt;
    rstat_r     <= rstat_nxt;
    out_sum_r   <= out_sum_nxt;
    out_hit_r   <= out_hit_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_stat_r  <= out_stat_nxt;
  end

  // sample memory
  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[pos_r[AW-1:0]] <= in_sample;
    end
    buf_rdata <= buf_mem[buf_raddr];
  end

  // per-tick sum memories
  always_ff @(posedge clk) begin
    if (acc_we) begin
      sum_mem[acc_waddr] <= sum_wdata;
      hit_mem[acc_waddr] <= hit_wdata;
    end
    sum_rdata <= sum_mem[acc_raddr];
    hit_rdata <= hit_mem[acc_raddr];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_threshold_r  <= RST_FIRST_THRESHOLD;
      first_precount_r   <= RST_FIRST_PRECOUNT;
      first_prewindow_r  <= RST_FIRST_PREWINDOW;
      second_threshold_r <= RST_SECOND_THRESHOLD;
      second_deadtime_r  <= RST_SECOND_DEADTIME;
      second_width_r     <= RST_SECOND_WIDTH;
      front_buffer_r     <= RST_FRONT_BUFFER;
      window_size_r      <= RST_WINDOW_SIZE;
    end else if (cfg_wr.valid && cfg_wr.ready) begin
      unique case (cfg_wr.index)
        CFG_FIRST_THRESHOLD:  first_threshold_r  <= cfg_wr.data;
        CFG_FIRST_PRECOUNT:   first_precount_r   <= cfg_wr.data[SPAN_W-1:0];
        CFG_FIRST_PREWINDOW:  first_prewindow_r  <= cfg_wr.data[SPAN_W-1:0];
        CFG_SECOND_THRESHOLD: second_threshold_r <= cfg_wr.data;
        CFG_SECOND_DEADTIME:  second_deadtime_r  <= cfg_wr.data[SPAN_W-1:0];
        CFG_SECOND_WIDTH:     second_width_r     <= cfg_wr.data[SPAN_W-1:0];
        CFG_FRONT_BUFFER:     front_buffer_r     <= cfg_wr.data;
        CFG_WINDOW_SIZE:      window_size_r      <= cfg_wr.data[SPAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // checks
  `PDWT_CHECK(a_scan_in_len, (state_r != S_T_RD0) || (tick_r < slen_r), "scan past channel")
  `PDWT_CHECK(a_acc_in_len, (state_r != S_A_WR) || (u_r < slen_r), "sum write past channel")
  `PDWT_CHECK(a_chans_bound, chans_r <= CW'(NUM_CHANNELS), "channel count overflow")
  `PDWT_NEXT(a_div_answers, (state_r == S_Q_DIV) && div_rsp.done, state_r == S_Q_CMP, "divider lost")
  `PDWT_CHECK(a_query_window, (state_r != S_Q_RD) || (u_r < len_r), "query past readout")

endmodule
